// ===== sv/brbd_pkg.sv =====
// Package for the byte ring buffer with delimiter search.
// Holds the sizes, command and status codes, the shared structs and a result helper.
// Used by the front end, the back end and the top level; depends on nothing.
`default_nettype none
package brbd_pkg;

    localparam int DEPTH      = 4096;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = IDX_W + 1;
    localparam int MAX_REMOVE = 64;
    localparam int REM_W      = $clog2(MAX_REMOVE + 1);
    localparam int MAX_SEP    = 8;
    localparam int SEP_K_W    = 3;
    localparam int SEP_LEN_W  = 4;
    localparam int SEP_W      = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SEP_W-1:0]     SEP_BYTES_RST = 64'h0000_0000_0000_0A0D;
    localparam logic [SEP_LEN_W-1:0] SEP_LEN_RST   = 4'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DRAIN  = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REM_READ,
        S_REM_EMIT,
        S_SRCH_READ,
        S_SRCH_CMP,
        S_SRCH_OUT
    } state_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] length;
        logic             last;
    } item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_last;
        status_t          status;
        logic [CNT_W-1:0] value;
        logic [CNT_W-1:0] fill_level;
    } result_t;

    function automatic result_t mk_res(input logic [7:0] b, input logic l,
                                       input status_t s, input logic [CNT_W-1:0] v,
                                       input logic [CNT_W-1:0] f);
        result_t r;
        r.out_byte   = b;
        r.out_last   = l;
        r.status     = s;
        r.value      = v;
        r.fill_level = f;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/brbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the byte store.
`default_nettype none
module brbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/brbd_front.sv =====
// Front end: takes input beats into a two-entry queue and decodes the command.
// Depends on brbd_pkg.
`default_nettype none
module brbd_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tlast,
    output brbd_pkg::item_t        item,
    output logic                   item_valid,
    input  wire logic              item_ready
);
    import brbd_pkg::*;

    item_t      q_reg [2];
    item_t      q_next [2];
    logic [1:0] cnt_reg, cnt_next;
    item_t      in_item;
    logic       push, pop;

    always_comb
    begin
        in_item.cmd       = cmd_t'(s_tuser);
        in_item.data_byte = s_tdata[7:0];
        in_item.length    = s_tdata[8 +: CNT_W];
        in_item.last      = s_tlast;
        s_tready   = (cnt_reg != 2'd2);
        item_valid = (cnt_reg != 2'd0);
        item       = q_reg[0];
        push = s_tvalid && s_tready;
        pop  = item_valid && item_ready;
        q_next[0] = q_reg[0];
        q_next[1] = q_reg[1];
        cnt_next  = cnt_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
            cnt_next  = cnt_next - 2'd1;
        end
        if (push)
        begin
            if (cnt_next == 2'd0)
            begin
                q_next[0] = in_item;
            end
            else
            begin
                q_next[1] = in_item;
            end
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next[0];
        q_reg[1] <= q_next[1];
    end
endmodule
`default_nettype wire

// ===== sv/brbd_back.sv =====
// Back end: carries out add, remove, drain and search against the byte store.
// Depends on brbd_pkg and brbd_ram.
`default_nettype none
module brbd_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire brbd_pkg::item_t                 item,
    input  wire logic                            item_valid,
    output logic                                 item_ready,
    input  wire logic [brbd_pkg::SEP_W-1:0]      sep_bytes,
    input  wire logic [brbd_pkg::SEP_LEN_W-1:0]  sep_len,
    output brbd_pkg::result_t                    res,
    output logic                                 res_valid,
    input  wire logic                            res_ready
);
    import brbd_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] wc_reg, wc_next, rc_reg, rc_next;
    logic             pend_reg, pend_next, refuse_reg, refuse_next;
    logic [REM_W-1:0] rem_n_reg, rem_n_next, rem_cnt_reg, rem_cnt_next;
    logic [CNT_W-1:0] si_reg, si_next, lim_reg, lim_next, sval_reg, sval_next;
    logic [SEP_K_W-1:0]   sk_reg, sk_next;
    logic [SEP_LEN_W-1:0] sn_reg, sn_next;
    result_t          out_reg, out_next;
    logic             ov_reg, ov_next;

    logic             out_free;
    logic [CNT_W-1:0] fill_now, mn, room;
    logic [SEP_LEN_W-1:0] sn_c;
    logic             refuse_now, wr_en, rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    brbd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wc_reg[IDX_W-1:0]),
        .wr_data (item.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res       = out_reg;
    assign res_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        wc_next = wc_reg;  rc_next = rc_reg;
        pend_next = pend_reg;  refuse_next = refuse_reg;
        rem_n_next = rem_n_reg;  rem_cnt_next = rem_cnt_reg;
        si_next = si_reg;  lim_next = lim_reg;  sval_next = sval_reg;
        sk_next = sk_reg;  sn_next = sn_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !res_ready;
        out_free = !ov_reg || res_ready;
        fill_now = wc_reg - rc_reg;
        room     = CNT_W'(DEPTH) - fill_now;
        mn       = (item.length > fill_now) ? fill_now : item.length;
        sn_c     = (sep_len > SEP_LEN_W'(MAX_SEP)) ? SEP_LEN_W'(MAX_SEP) : sep_len;
        refuse_now = pend_reg ? refuse_reg : (item.length > room);
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = rc_reg[IDX_W-1:0];
        item_ready = (state_reg == S_IDLE) && out_free;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid && out_free)
                begin
                    unique case (item.cmd)
                        CMD_ADD:
                        begin
                            wr_en = !refuse_now && !fill_now[IDX_W];
                            if (wr_en)
                            begin
                                wc_next = wc_reg + 1'b1;
                            end
                            pend_next   = !item.last;
                            refuse_next = !item.last && refuse_now;
                            ov_next  = 1'b1;
                            out_next = mk_res(8'd0, 1'b1, wr_en ? STAT_OK : STAT_REFUSED,
                                              '0, fill_now + CNT_W'(wr_en));
                        end
                        CMD_REMOVE:
                        begin
                            if (fill_now == '0)
                            begin
                                ov_next  = 1'b1;
                                out_next = mk_res(8'd0, 1'b1, STAT_EMPTY, '0, fill_now);
                            end
                            else if (mn == '0)
                            begin
                                ov_next  = 1'b1;
                                out_next = mk_res(8'd0, 1'b1, STAT_OK, '0, fill_now);
                            end
                            else
                            begin
                                rem_n_next   = (mn > CNT_W'(MAX_REMOVE)) ?
                                               REM_W'(MAX_REMOVE) : mn[REM_W-1:0];
                                rem_cnt_next = '0;
                                state_next   = S_REM_READ;
                            end
                        end
                        CMD_DRAIN:
                        begin
                            rc_next  = rc_reg + mn;
                            ov_next  = 1'b1;
                            out_next = mk_res(8'd0, 1'b1, STAT_OK, mn, fill_now - mn);
                        end
                        CMD_SEARCH:
                        begin
                            if (sn_c == '0 || fill_now < CNT_W'(sn_c))
                            begin
                                ov_next  = 1'b1;
                                out_next = mk_res(8'd0, 1'b1, STAT_OK, '0, fill_now);
                            end
                            else
                            begin
                                sn_next  = sn_c;
                                si_next  = '0;
                                sk_next  = '0;
                                lim_next = fill_now - CNT_W'(sn_c);
                                state_next = S_SRCH_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_REM_READ:
            begin
                rd_en = 1'b1;
                state_next = S_REM_EMIT;
            end
            S_REM_EMIT:
            begin
                if (out_free)
                begin
                    rc_next      = rc_reg + 1'b1;
                    rem_cnt_next = rem_cnt_reg + 1'b1;
                    ov_next  = 1'b1;
                    out_next = mk_res(rd_data, rem_cnt_next == rem_n_reg, STAT_OK,
                                      CNT_W'(rem_n_reg), fill_now - 1'b1);
                    state_next = (rem_cnt_next == rem_n_reg) ? S_IDLE : S_REM_READ;
                end
            end
            S_SRCH_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = rc_reg[IDX_W-1:0] + si_reg[IDX_W-1:0] + IDX_W'(sk_reg);
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (rd_data == sep_bytes[{sk_reg, 3'b000} +: 8])
                begin
                    if (SEP_LEN_W'(sk_reg) + 1'b1 == sn_reg)
                    begin
                        sval_next  = si_reg + CNT_W'(sn_reg);
                        state_next = S_SRCH_OUT;
                    end
                    else
                    begin
                        sk_next    = sk_reg + 1'b1;
                        state_next = S_SRCH_READ;
                    end
                end
                else if (si_reg == lim_reg)
                begin
                    sval_next  = '0;
                    state_next = S_SRCH_OUT;
                end
                else
                begin
                    si_next    = si_reg + 1'b1;
                    sk_next    = '0;
                    state_next = S_SRCH_READ;
                end
            end
            S_SRCH_OUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    out_next = mk_res(8'd0, 1'b1, STAT_OK, sval_reg, fill_now);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wc_reg     <= '0;
            rc_reg     <= '0;
            pend_reg   <= 1'b0;
            refuse_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wc_reg     <= wc_next;
            rc_reg     <= rc_next;
            pend_reg   <= pend_next;
            refuse_reg <= refuse_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_n_reg   <= rem_n_next;
        rem_cnt_reg <= rem_cnt_next;
        si_reg      <= si_next;
        lim_reg     <= lim_next;
        sval_reg    <= sval_next;
        sk_reg      <= sk_next;
        sn_reg      <= sn_next;
        out_reg     <= out_next;
    end

    // fill never passes the store size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (wc_reg - rc_reg) <= CNT_W'(DEPTH))
        else $error("fill level above depth");

    a_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REM_EMIT |-> rem_cnt_reg < rem_n_reg && rem_n_reg != '0)
        else $error("remove count overrun");

    a_srch_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SRCH_CMP |-> si_reg <= lim_reg && CNT_W'(sk_reg) < CNT_W'(sn_reg))
        else $error("search position out of range");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !item_ready)
        else $error("item taken while busy");
endmodule
`default_nettype wire

// ===== sv/byte_ring_buffer_with_delimiter_search.sv =====
// Top level of the byte ring buffer with delimiter search.
// Depends on brbd_pkg, brbd_front, brbd_back (and brbd_ram below it).
//
// Usage:
//  - Input stream s_*: one beat per command. tuser = command (add, remove, drain,
//    search); tdata = data_byte, length; tlast = end of an add run.
//  - Output stream m_*: one beat per result. tdata = out_byte, value, fill_level;
//    tuser = status; tlast = final result of the command.
//  - cfg_*: register writes (index 0 separator bytes, 1 separator length),
//    always ready; the user writes them only while the block is idle (the block itself does not enforce this).
//  - A two-entry queue decouples input from the executing back end.
//  - Add and drain: done directly from the idle state, one result per beat.
//  - Remove: each byte out takes a store read, then a result, up to 64 bytes.
//  - Search: each byte compared takes a store read, then a compare, on the
//    single store read port.
//  - Reset empties the store (counts cleared), closes any add run and loads the
//    separator CR LF. No clearing pass is needed.
//  - A stalled m_tready holds the output register; the back end then stops and
//    the input queue fills, after which s_tready falls.
`default_nettype none
module byte_ring_buffer_with_delimiter_search (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [23:0]                     s_tdata,   // data_byte[7:0], length[20:8]
    input  wire logic [1:0]                      s_tuser,   // command
    input  wire logic                            s_tlast,   // last
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [39:0]                          m_tdata,   // out_byte, value, fill_level
    output logic [1:0]                           m_tuser,   // status
    output logic                                 m_tlast,   // out_last
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [brbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brbd_pkg::SEP_W-1:0]      cfg_data
);
    import brbd_pkg::*;

    item_t   item;
    logic    item_valid, item_ready;
    result_t res;
    logic    res_valid;
    logic [SEP_W-1:0]     sep_bytes_reg;
    logic [SEP_LEN_W-1:0] sep_len_reg;

    assign cfg_ready = 1'b1;

    // separator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_bytes_reg <= SEP_BYTES_RST;
            sep_len_reg   <= SEP_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEP_BYTES: sep_bytes_reg <= cfg_data;
                CFG_SEP_LEN:   sep_len_reg   <= cfg_data[SEP_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    brbd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    brbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sep_bytes  (sep_bytes_reg),
        .sep_len    (sep_len_reg),
        .res        (res),
        .res_valid  (res_valid),
        .res_ready  (m_tready)
    );

    // result beat packing
    assign m_tvalid = res_valid;
    assign m_tdata  = {6'd0, res.fill_level, res.value, res.out_byte};
    assign m_tuser  = res.status;
    assign m_tlast  = res.out_last;
endmodule
`default_nettype wire
